/* hw/rtl/qvr_pkg.sv */
// qvr_pkg: widths, types and saturation limits for the quaternion vector rotator.
// No dependencies; used by every file under hw/rtl.
`timescale 1ns / 1ps

package qvr_pkg;

  localparam int DATA_WIDTH     = 16;
  localparam int QUAT_FRAC_BITS = 14;

  // product of two quaternion parts
  localparam int PROD_W = 2 * DATA_WIDTH;
  // rotation matrix entry: sum of up to four products, doubled
  localparam int MAT_W  = PROD_W + 2;
  // matrix entry times vector component
  localparam int TERM_W = MAT_W + DATA_WIDTH;
  // sum of three terms plus rounding headroom
  localparam int SUM_W  = TERM_W + 2;
  localparam int RSHIFT = 2 * QUAT_FRAC_BITS;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [MAT_W-1:0]      mat_t;
  typedef logic signed [TERM_W-1:0]     term_t;
  typedef logic signed [SUM_W-1:0]      sum_t;

  typedef mat_t mat3_t [3][3];

  // stage enables for the matrix front end
  typedef struct packed {
    logic prod;
    logic mat;
  } mat_en_t;

  localparam data_t DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // 0.5 in the scale of the accumulated sum, for round half up
  localparam sum_t RND_HALF = sum_t'(1) << (RSHIFT - 1);

endpackage

/* hw/rtl/quaternion_vector_rotate.sv */
// quaternion_vector_rotate: rotates a 3-D vector by q * (0,v) * conj(q), unnormalized q.
// Throughput one transaction per cycle while out_stall is low.
// The five stages are the part products, matrix entries, the nine matrix-vector
// multipliers, the three-term sum with rounding offset, and the shift plus saturation.
// rst (synchronous, active high) clears the stage valid bits only; data regs keep contents.
// Depends on qvr_pkg and qvr_mat.
`timescale 1ns / 1ps

module quaternion_vector_rotate (
  input  logic           clk,
  input  logic           rst,
  // input channel
  input  logic           in_valid,
  output logic           in_stall,
  input  qvr_pkg::data_t quat_w,
  input  qvr_pkg::data_t quat_x,
  input  qvr_pkg::data_t quat_y,
  input  qvr_pkg::data_t quat_z,
  input  qvr_pkg::data_t vec_x,
  input  qvr_pkg::data_t vec_y,
  input  qvr_pkg::data_t vec_z,
  // result channel
  output logic           out_valid,
  input  logic           out_stall,
  output qvr_pkg::data_t rot_x,
  output qvr_pkg::data_t rot_y,
  output qvr_pkg::data_t rot_z,
  output logic           saturated
);

  localparam int NSTG = 5;

  // Stage valid bits and enables. A stage loads when it is empty or its successor is
  // loading, so bubbles collapse; a stall holds the full stages up to the first bubble.
  logic [NSTG:1] vld;
  logic [NSTG:1] en;

  always_comb begin
    en[NSTG] = !vld[NSTG] || !out_stall;
    for (int k = NSTG - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_stall  = !en[1];
  assign out_valid = vld[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= in_valid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stages 1-2: rotation matrix from the quaternion.
  qvr_pkg::mat_en_t mat_en;
  qvr_pkg::mat3_t   mat;

  assign mat_en.prod = en[1];
  assign mat_en.mat  = en[2];

  qvr_mat u_mat (
    .clk    (clk),
    .en     (mat_en),
    .quat_w (quat_w),
    .quat_x (quat_x),
    .quat_y (quat_y),
    .quat_z (quat_z),
    .mat    (mat)
  );

  // Vector rides alongside the matrix front end.
  qvr_pkg::data_t vec1 [3];
  qvr_pkg::data_t vec2 [3];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      vec1[0] <= vec_x;
      vec1[1] <= vec_y;
      vec1[2] <= vec_z;
    end
    if (en[2]) begin
      vec2 <= vec1;
    end
  end

  // Stage 3: nine matrix-vector products, exact.
  qvr_pkg::term_t term [3][3];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          term[i][j] <= qvr_pkg::TERM_W'(mat[i][j]) * qvr_pkg::TERM_W'(vec2[j]);
        end
      end
    end
  end

  // Stage 4: row sums with the half-LSB offset for round half up.
  qvr_pkg::sum_t acc [3];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < 3; i++) begin
        acc[i] <= qvr_pkg::SUM_W'(term[i][0]) + qvr_pkg::SUM_W'(term[i][1])
                + qvr_pkg::SUM_W'(term[i][2]) + qvr_pkg::RND_HALF;
      end
    end
  end

  // Stage 5: drop the fraction bits, clip to the data range.
  qvr_pkg::sum_t  rnd  [3];
  qvr_pkg::data_t sat  [3];
  logic [2:0]     clip;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = acc[i] >>> qvr_pkg::RSHIFT;
      if (rnd[i] > qvr_pkg::SUM_W'(qvr_pkg::DATA_MAX)) begin
        sat[i]  = qvr_pkg::DATA_MAX;
        clip[i] = 1'b1;
      end else if (rnd[i] < qvr_pkg::SUM_W'(qvr_pkg::DATA_MIN)) begin
        sat[i]  = qvr_pkg::DATA_MIN;
        clip[i] = 1'b1;
      end else begin
        sat[i]  = rnd[i][qvr_pkg::DATA_WIDTH-1:0];
        clip[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      rot_x     <= sat[0];
      rot_y     <= sat[1];
      rot_z     <= sat[2];
      saturated <= |clip;
    end
  end

endmodule

/* hw/rtl/qvr_mat.sv */
// qvr_mat: two-stage front end that turns a quaternion into the 3x3 rotation matrix.
// Depends on qvr_pkg. Stage 1 forms the ten part products, stage 2 the entries.
`timescale 1ns / 1ps

module qvr_mat (
  input  logic            clk,
  input  qvr_pkg::mat_en_t en,
  input  qvr_pkg::data_t  quat_w,
  input  qvr_pkg::data_t  quat_x,
  input  qvr_pkg::data_t  quat_y,
  input  qvr_pkg::data_t  quat_z,
  output qvr_pkg::mat3_t  mat
);

  qvr_pkg::prod_t ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;

  function automatic qvr_pkg::mat_t ext(input qvr_pkg::prod_t p);
    return qvr_pkg::MAT_W'(p);
  endfunction

  // stage 1: part products, exact
  always_ff @(posedge clk) begin
    if (en.prod) begin
      ww <= quat_w * quat_w;
      xx <= quat_x * quat_x;
      yy <= quat_y * quat_y;
      zz <= quat_z * quat_z;
      xy <= quat_x * quat_y;
      wz <= quat_w * quat_z;
      xz <= quat_x * quat_z;
      wy <= quat_w * quat_y;
      yz <= quat_y * quat_z;
      wx <= quat_w * quat_x;
    end
  end

  // stage 2: matrix entries, scale 2^(2F)
  always_ff @(posedge clk) begin
    if (en.mat) begin
      mat[0][0] <= ext(ww) + ext(xx) - ext(yy) - ext(zz);
      mat[1][1] <= ext(ww) - ext(xx) + ext(yy) - ext(zz);
      mat[2][2] <= ext(ww) - ext(xx) - ext(yy) + ext(zz);
      mat[0][1] <= (ext(xy) - ext(wz)) <<< 1;
      mat[0][2] <= (ext(xz) + ext(wy)) <<< 1;
      mat[1][0] <= (ext(xy) + ext(wz)) <<< 1;
      mat[1][2] <= (ext(yz) - ext(wx)) <<< 1;
      mat[2][0] <= (ext(xz) - ext(wy)) <<< 1;
      mat[2][1] <= (ext(yz) + ext(wx)) <<< 1;
    end
  end

endmodule

/* hw/rtl/qvr_checker.sv */
// qvr_checker: port-level assertions for quaternion_vector_rotate, bound to the top level.
// Depends on qvr_pkg.
`timescale 1ns / 1ps

module qvr_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input qvr_pkg::data_t rot_x,
  input qvr_pkg::data_t rot_y,
  input qvr_pkg::data_t rot_z,
  input logic           saturated
);

  // held result transaction keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rot_x) && $stable(rot_y)
      && $stable(rot_z) && $stable(saturated))
    else $error("result changed while stalled");

  // input backpressure only comes from output backpressure
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled with output free");

  // an accepted input reaches the output through all stages when the output is not stalled
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
      ##1 !out_stall |=> out_valid)
    else $error("result missing after pipeline latency");

  // a clipped result shows at least one component at a limit
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      rot_x == qvr_pkg::DATA_MAX || rot_x == qvr_pkg::DATA_MIN ||
      rot_y == qvr_pkg::DATA_MAX || rot_y == qvr_pkg::DATA_MIN ||
      rot_z == qvr_pkg::DATA_MAX || rot_z == qvr_pkg::DATA_MIN)
    else $error("saturated flag without a clipped component");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (.*);
